@@ hw/rtl/iaxs_pkg.sv @@
// Shared types and constants for the input axis smoother.
package iaxs_pkg;

  typedef enum logic [1:0] {
    OP_FSTART = 2'd0,
    OP_UPDATE = 2'd1,
    OP_FEND   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_SMUL,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic div_step;
    logic smul;
    logic fin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic smooth_zero;
    logic div_last;
    logic out_busy;
  } sts_t;

  localparam logic        REG_SMOOTH_TIME = 1'b0;
  localparam logic        REG_MIN_SPEED   = 1'b1;
  localparam logic [15:0] Q15_ONE         = 16'h8000;
  localparam logic [4:0]  DIV_LAST        = 5'd16;

endpackage

@@ hw/rtl/input_axis_smoother_core.sv @@
// Top level of the input axis smoother: register port, sequencer and datapath.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready  op, raw_sample, delta_time, interp_coeff
//   out_     output     out_valid/out_ready axis_value, changed
//   cfg      input      APB psel/penable   smooth_time (0x0), min_speed (0x4)
//
// One transaction at a time: frame start and unused codes run MUL, frame end MUL
// and ACC, an update MUL, ACC, then DIV, SMUL, FIN if smoothing is on, then OUT;
// DIV is the 17-step restoring divider forming the weight dt/(smooth_time+dt).
// Synchronous reset clears the sequencer, config, frame state and out_valid only.
// A stalled result holds in the output register; the next transaction is taken
// meanwhile, and an update waits in its final cycle until the register is free.
module input_axis_smoother_core
  import iaxs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [1:0]  in_op,
  input  logic signed [15:0] in_raw_sample,
  input  logic        [15:0] in_delta_time,
  input  logic        [15:0] in_interp_coeff,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_axis_value,
  output logic               out_changed,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  logic [15:0] smooth_time_r;
  logic [14:0] min_speed_r;
  logic        cfg_wr;
  cmd_t        cmd;
  sts_t        sts;
  state_t      ctrl_st;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_time_r <= '0;
      min_speed_r   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SMOOTH_TIME: smooth_time_r <= pwdata[15:0];
        REG_MIN_SPEED:   min_speed_r   <= pwdata[14:0];
        default:         smooth_time_r <= smooth_time_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SMOOTH_TIME: prdata = {16'h0000, smooth_time_r};
      REG_MIN_SPEED:   prdata = {17'h00000, min_speed_r};
      default:         prdata = '0;
    endcase
  end

  iaxs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .st       (ctrl_st)
  );

  iaxs_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_raw_sample   (in_raw_sample),
    .in_delta_time   (in_delta_time),
    .in_interp_coeff (in_interp_coeff),
    .smooth_time     (smooth_time_r),
    .min_speed       (min_speed_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_axis_value  (out_axis_value),
    .out_changed     (out_changed)
  );

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctrl_st) == ST_OUT)
    else $error("result raised outside the output step");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> ctrl_st == ST_IDLE)
    else $error("input taken while busy");

  a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_st == ST_FIN |=> ctrl_st == ST_OUT)
    else $error("final step not followed by output step");

  a_cfg_smooth: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && paddr[2] == REG_SMOOTH_TIME) |=> smooth_time_r == $past(pwdata[15:0]))
    else $error("smooth time register not written");

endmodule

@@ hw/rtl/iaxs_ctrl.sv @@
// Sequencer for the input axis smoother: issues datapath commands per event.
module iaxs_ctrl
  import iaxs_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd,
  output state_t st
);

  state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) st_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (sts.op == OP_UPDATE || sts.op == OP_FEND) st_nxt = ST_ACC;
        else st_nxt = ST_IDLE;
      end
      ST_ACC: begin
        if (sts.op != OP_UPDATE) st_nxt = ST_IDLE;
        else if (sts.smooth_zero) st_nxt = ST_OUT;
        else st_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_last) st_nxt = ST_SMUL;
      end
      ST_SMUL: st_nxt = ST_FIN;
      ST_FIN:  st_nxt = ST_OUT;
      ST_OUT: begin
        if (!sts.out_busy) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_MUL:  cmd.mul      = 1'b1;
      ST_ACC:  cmd.acc      = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_SMUL: cmd.smul     = 1'b1;
      ST_FIN:  cmd.fin      = 1'b1;
      ST_OUT:  cmd.load_out = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

  assign st = st_r;

endmodule

@@ hw/rtl/iaxs_dpath.sv @@
// Datapath for the input axis smoother: state, products, divider, output register.
module iaxs_dpath
  import iaxs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic        [1:0]  in_op,
  input  logic signed [15:0] in_raw_sample,
  input  logic        [15:0] in_delta_time,
  input  logic        [15:0] in_interp_coeff,
  input  logic        [15:0] smooth_time,
  input  logic        [14:0] min_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_axis_value,
  output logic               out_changed
);

  op_t                op_r;
  logic signed [15:0] raw_in_r;
  logic        [15:0] dt_r;
  logic        [15:0] coeff_r;

  logic signed [15:0] latched_raw_r;
  logic signed [23:0] residual_r;
  logic        [15:0] prior_r;
  logic signed [15:0] cur_r;

  logic signed [33:0] prod_r;
  logic signed [15:0] target_r;
  logic signed [15:0] nv_r;
  logic        [16:0] den_r;
  logic        [16:0] rem_r;
  logic        [16:0] q_r;
  logic        [4:0]  cnt_r;
  logic signed [16:0] dif_r;
  logic               lin_r;
  logic               zero_r;
  logic signed [35:0] prod2_r;

  logic               out_valid_r;
  logic signed [15:0] out_value_r;
  logic               out_changed_r;

  logic signed [17:0] mul_a;
  logic signed [33:0] prod_c;
  logic signed [33:0] prod_rnd;
  logic signed [18:0] term;
  logic signed [24:0] sum25;
  logic signed [23:0] res_sat;
  logic signed [15:0] tgt_sat;
  logic        [16:0] den_c;
  logic        [32:0] num_c;
  logic        [17:0] trial;
  logic               ge;
  logic signed [16:0] dif_c;
  logic        [16:0] mag_c;
  logic signed [17:0] mul2_a;
  logic signed [17:0] mul2_b;
  logic signed [35:0] prod2_c;
  logic signed [35:0] prod2_rnd;
  logic signed [19:0] rnd;
  logic signed [19:0] old20;
  logic signed [19:0] tgt20;
  logic signed [19:0] s20;
  logic signed [19:0] nv20;
  logic signed [15:0] nv_c;

  always_comb begin
    if (op_r == OP_FEND) begin
      mul_a = $signed({2'b00, coeff_r}) - $signed({2'b00, prior_r});
    end else begin
      mul_a = $signed({2'b00, Q15_ONE}) - $signed({2'b00, prior_r});
    end
    prod_c   = mul_a * latched_raw_r;
    prod_rnd = prod_r + 34'sd16384;
    term     = prod_rnd[33:15];
    sum25    = {residual_r[23], residual_r} + {{6{term[18]}}, term};
    if (sum25 > 25'sd8388607) res_sat = 24'sh7FFFFF;
    else if (sum25 < -25'sd8388608) res_sat = 24'sh800000;
    else res_sat = sum25[23:0];
    if (sum25 > 25'sd32767) tgt_sat = 16'sh7FFF;
    else if (sum25 < -25'sd32768) tgt_sat = 16'sh8000;
    else tgt_sat = sum25[15:0];
  end

  always_comb begin
    den_c = {1'b0, smooth_time} + {1'b0, dt_r};
    num_c = {1'b0, dt_r, 16'h0000} + {17'h00000, den_c[16:1]};
    trial = {rem_r, q_r[16]};
    ge    = trial >= {1'b0, den_r};
  end

  always_comb begin
    dif_c   = $signed({target_r[15], target_r}) - $signed({cur_r[15], cur_r});
    mag_c   = dif_c[16] ? 17'(-dif_c) : 17'(dif_c);
    mul2_a  = lin_r ? $signed({3'b000, min_speed}) : $signed({dif_r[16], dif_r});
    mul2_b  = $signed({1'b0, q_r});
    prod2_c = mul2_a * mul2_b;
  end

  always_comb begin
    prod2_rnd = prod2_r + 36'sd32768;
    rnd       = prod2_rnd[35:16];
    old20     = {{4{cur_r[15]}}, cur_r};
    tgt20     = {{4{target_r[15]}}, target_r};
    s20       = old20 + rnd;
    nv20      = tgt20;
    if (zero_r) begin
      nv20 = tgt20;
    end else if (lin_r) begin
      if (!dif_r[16]) begin
        s20  = old20 + rnd;
        nv20 = (s20 > tgt20) ? tgt20 : s20;
      end else begin
        s20  = old20 - rnd;
        nv20 = (s20 < tgt20) ? tgt20 : s20;
      end
    end else begin
      nv20 = s20;
    end
    if (nv20 > 20'sd32767) nv_c = 16'sh7FFF;
    else if (nv20 < -20'sd32768) nv_c = 16'sh8000;
    else nv_c = nv20[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_FSTART;
    end else if (cmd.capture) begin
      op_r <= op_t'(in_op);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_in_r <= in_raw_sample;
      dt_r     <= in_delta_time;
      coeff_r  <= (in_interp_coeff > Q15_ONE) ? Q15_ONE : in_interp_coeff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_raw_r <= '0;
      residual_r    <= '0;
      prior_r       <= '0;
      cur_r         <= '0;
    end else begin
      if (cmd.mul && op_r == OP_FSTART) begin
        latched_raw_r <= raw_in_r;
      end
      if (cmd.acc && op_r == OP_FEND) begin
        residual_r <= res_sat;
        prior_r    <= coeff_r;
      end
      if (cmd.acc && op_r == OP_UPDATE) begin
        residual_r <= '0;
        prior_r    <= '0;
      end
      if (cmd.load_out) begin
        cur_r <= nv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod_c;
    end
    if (cmd.acc) begin
      target_r <= tgt_sat;
      nv_r     <= tgt_sat;
      den_r    <= den_c;
      rem_r    <= {1'b0, num_c[32:17]};
      q_r      <= num_c[16:0];
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? 17'(trial - {1'b0, den_r}) : trial[16:0];
      q_r    <= {q_r[15:0], ge};
      dif_r  <= dif_c;
      lin_r  <= mag_c < {2'b00, min_speed};
      zero_r <= dif_c == 17'sd0;
    end
    if (cmd.smul) begin
      prod2_r <= prod2_c;
    end
    if (cmd.fin) begin
      nv_r <= nv_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.acc) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value_r   <= nv_r;
      out_changed_r <= nv_r != cur_r;
    end
  end

  assign sts.op          = op_r;
  assign sts.smooth_zero = smooth_time == 16'h0000;
  assign sts.div_last    = cnt_r == DIV_LAST;
  assign sts.out_busy    = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_axis_value = out_value_r;
  assign out_changed    = out_changed_r;

endmodule

@@ dv/input_axis_smoother_core_tb.sv @@
// Self-checking testbench for the input axis smoother: directed table, then random frame traffic.
module input_axis_smoother_core_tb;
  import iaxs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         PHASE_ITEMS   = 120;
  localparam int         NUM_PHASES    = 8;

  typedef struct packed {
    logic signed [15:0] value;
    logic               chg;
  } axis_result_t;

  typedef enum logic [1:0] {
    ROW_EVENT,
    ROW_CHECK,
    ROW_CFG
  } row_kind_t;

  // for config rows dt carries smooth_time and coeff carries min_speed
  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         op;
    logic signed [15:0] raw;
    logic [15:0]        dt;
    logic [15:0]        coeff;
    logic signed [15:0] exp_value;
    logic               exp_chg;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [24] = '{
    '{ROW_CHECK, OP_UPDATE, 16'sh0000, 16'd0,     16'd0,     16'sh0000, 1'b0},
    '{ROW_EVENT, OP_FSTART, 16'sh7fff, 16'd0,     16'd0,     16'sh0000, 1'b0},
    '{ROW_CHECK, OP_UPDATE, 16'sh0000, 16'd65535, 16'd0,     16'sh7fff, 1'b1},
    '{ROW_EVENT, OP_FSTART, 16'sh8000, 16'd0,     16'd0,     16'sh0000, 1'b0},
    '{ROW_CHECK, OP_UPDATE, 16'sh0000, 16'd0,     16'd0,     16'sh8000, 1'b1},
    '{ROW_EVENT, OP_FEND,   16'sh0000, 16'd0,     16'd65535, 16'sh0000, 1'b0},
    '{ROW_CHECK, OP_UPDATE, 16'sh0000, 16'd0,     16'd0,     16'sh8000, 1'b0},
    '{ROW_EVENT, OP_UNUSED, 16'shffff, 16'd65535, 16'd65535, 16'sh0000, 1'b0},
    '{ROW_EVENT, OP_FSTART, 16'sh7fff, 16'd0,     16'd0,     16'sh0000, 1'b0},
    '{ROW_EVENT, OP_FEND,   16'sh0000, 16'd0,     16'd16384, 16'sh0000, 1'b0},
    '{ROW_EVENT, OP_FEND,   16'sh0000, 16'd0,     16'd32768, 16'sh0000, 1'b0},
    '{ROW_CHECK, OP_UPDATE, 16'sh0000, 16'd0,     16'd0,     16'sh7fff, 1'b1},
    '{ROW_CFG,   OP_FSTART, 16'sh0000, 16'd1000,  16'd32767, 16'sh0000, 1'b0},
    '{ROW_CHECK, OP_UPDATE, 16'sh0000, 16'd0,     16'd0,     16'sh7fff, 1'b0},
    '{ROW_EVENT, OP_FSTART, 16'sh0000, 16'd0,     16'd0,     16'sh0000, 1'b0},
    '{ROW_EVENT, OP_UPDATE, 16'sh0000, 16'd1000,  16'd0,     16'sh0000, 1'b0},
    '{ROW_EVENT, OP_UPDATE, 16'sh0000, 16'd65535, 16'd0,     16'sh0000, 1'b0},
    '{ROW_CFG,   OP_FSTART, 16'sh0000, 16'd65535, 16'd0,     16'sh0000, 1'b0},
    '{ROW_EVENT, OP_FSTART, 16'sh8000, 16'd0,     16'd0,     16'sh0000, 1'b0},
    '{ROW_CHECK, OP_UPDATE, 16'sh0000, 16'd0,     16'd0,     16'sh0000, 1'b0},
    '{ROW_EVENT, OP_UPDATE, 16'sh0000, 16'd65535, 16'd0,     16'sh0000, 1'b0},
    '{ROW_EVENT, OP_FEND,   16'sh0000, 16'd0,     16'd1,     16'sh0000, 1'b0},
    '{ROW_EVENT, OP_FEND,   16'sh0000, 16'd0,     16'd32767, 16'sh0000, 1'b0},
    '{ROW_EVENT, OP_UPDATE, 16'sh0000, 16'd1,     16'd0,     16'sh0000, 1'b0}
  };

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_ready;
  logic [1:0]         in_op           = OP_FSTART;
  logic signed [15:0] in_raw_sample   = '0;
  logic [15:0]        in_delta_time   = '0;
  logic [15:0]        in_interp_coeff = '0;
  logic               out_valid;
  logic               out_ready       = 1'b0;
  logic signed [15:0] out_axis_value;
  logic               out_changed;
  logic               psel            = 1'b0;
  logic               penable         = 1'b0;
  logic               pwrite          = 1'b0;
  logic [2:0]         paddr           = '0;
  logic [31:0]        pwdata          = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic [15:0]        smooth_cfg    = '0;
  logic [14:0]        min_speed_cfg = '0;
  logic signed [15:0] cur_val       = '0;
  logic signed [15:0] raw_latch     = '0;
  logic signed [23:0] resid         = '0;
  logic [15:0]        coeff_prev    = '0;

  axis_result_t pending_axis_results[$];
  int           mismatches     = 0;
  int           cycle_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;

  input_axis_smoother_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_raw_sample  (in_raw_sample),
    .in_delta_time  (in_delta_time),
    .in_interp_coeff(in_interp_coeff),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_axis_value (out_axis_value),
    .out_changed    (out_changed),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk = ~clk;

  function automatic longint rnd_shift(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic bit smooth_step(input logic [1:0] op, input logic signed [15:0] raw,
                                     input logic [15:0] dt, input logic [15:0] coeff,
                                     output axis_result_t res);
    longint c, target, prev, nv, den, w, dif, mag, step;
    res = '0;
    if (op == OP_FSTART) begin
      raw_latch = raw;
      return 1'b0;
    end
    if (op == OP_FEND) begin
      c = (coeff > Q15_ONE) ? longint'(Q15_ONE) : longint'(coeff);
      resid = 24'(sat(longint'(resid) +
                      rnd_shift((c - longint'(coeff_prev)) * longint'(raw_latch), 15),
                      -8388608, 8388607));
      coeff_prev = 16'(c);
      return 1'b0;
    end
    if (op != OP_UPDATE) begin
      return 1'b0;
    end
    prev = longint'(cur_val);
    target = sat(longint'(resid) +
                 rnd_shift((longint'(Q15_ONE) - longint'(coeff_prev)) * longint'(raw_latch), 15),
                 -32768, 32767);
    resid = '0;
    coeff_prev = '0;
    if (smooth_cfg == 16'd0) begin
      nv = target;
    end else begin
      den = longint'(smooth_cfg) + longint'(dt);
      w = ((longint'(dt) <<< 16) + (den >>> 1)) / den;
      dif = target - prev;
      mag = (dif < 0) ? -dif : dif;
      if (dif == 0) begin
        nv = target;
      end else if (mag < longint'(min_speed_cfg)) begin
        step = rnd_shift(longint'(min_speed_cfg) * w, 16);
        if (dif > 0) begin
          nv = (prev + step > target) ? target : prev + step;
        end else begin
          nv = (prev - step < target) ? target : prev - step;
        end
      end else begin
        nv = prev + rnd_shift(dif * w, 16);
      end
    end
    nv = sat(nv, -32768, 32767);
    cur_val = 16'(nv);
    res.value = 16'(nv);
    res.chg = (nv != prev);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 40) begin
      $display("mismatch %s at cycle %0d: got %0d, expected %0d", what, cycle_count, got, want);
    end
    mismatches++;
  endtask

  task automatic check_axis_result();
    axis_result_t want;
    if (pending_axis_results.size() == 0) begin
      report_mismatch("unexpected result", out_axis_value, 0);
    end else begin
      want = pending_axis_results.pop_front();
      if (out_axis_value !== want.value) begin
        report_mismatch("axis_value", out_axis_value, want.value);
      end
      if (out_changed !== want.chg) begin
        report_mismatch("changed", out_changed, want.chg);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_axis_result();
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] op, input logic signed [15:0] raw,
                           input logic [15:0] dt, input logic [15:0] coeff,
                           input bit use_typed = 1'b0, input axis_result_t typed_res = '0);
    axis_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_raw_sample   <= raw;
    in_delta_time   <= dt;
    in_interp_coeff <= coeff;
    if (smooth_step(op, raw, dt, coeff, predicted)) begin
      pending_axis_results.push_back(use_typed ? typed_res : predicted);
    end
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_axis_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_SMOOTH_TIME) begin
      smooth_cfg = data[15:0];
    end else begin
      min_speed_cfg = data[14:0];
    end
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_raw();
    int r;
    int off;
    r = $urandom_range(99);
    off = $urandom_range(2048);
    off -= 1024;
    if (r < 15) begin
      return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end
    if (r < 50) begin
      return 16'(sat(longint'(cur_val) + longint'(off), -32768, 32767));
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_dt();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      return 16'd0;
    end
    if (r < 35) begin
      return 16'($urandom_range(63));
    end
    if (r < 50) begin
      return smooth_cfg;
    end
    return 16'($urandom_range(65535));
  endfunction

  task automatic drive_pump(input int pairs, input bit upward);
    for (int j = 0; j < pairs; j++) begin
      push_item(OP_FSTART, upward ? 16'sh7fff : 16'sh8000, 16'd0, 16'd0);
      push_item(OP_FEND, 16'sh0000, 16'd0, Q15_ONE);
      push_item(OP_FSTART, upward ? 16'sh8000 : 16'sh7fff, 16'd0, 16'd0);
      push_item(OP_FEND, 16'sh0000, 16'd0, 16'd0);
    end
    push_item(OP_UPDATE, 16'sh0000, pick_dt(), 16'd0);
  endtask

  task automatic drive_sequence(output int count);
    int         pick;
    int         n_ends;
    int         pairs;
    logic [1:0] op;
    logic [15:0] c;
    logic [15:0] c_lo;
    pick = $urandom_range(99);
    if (pick < 12) begin
      op = 2'($urandom_range(3));
      push_item(op, 16'($urandom), 16'($urandom), 16'($urandom));
      count = (op != OP_UNUSED) ? 1 : 0;
    end else if (pick < 16) begin
      pairs = $urandom_range(24, 2);
      drive_pump(pairs, 1'($urandom_range(1)));
      count = 4 * pairs + 1;
    end else begin
      push_item(OP_FSTART, pick_raw(), 16'($urandom), 16'($urandom));
      n_ends = $urandom_range(3);
      c_lo = '0;
      for (int j = 0; j < n_ends; j++) begin
        if ($urandom_range(9) == 0) begin
          c = 16'($urandom_range(65535, 32769));
        end else begin
          c = 16'($urandom_range(32768, c_lo));
        end
        c_lo = (c > Q15_ONE) ? Q15_ONE : c;
        push_item(OP_FEND, 16'($urandom), 16'($urandom), c);
      end
      push_item(OP_UPDATE, 16'($urandom), pick_dt(), 16'($urandom));
      count = n_ends + 2;
    end
  endtask

  task automatic run_phase(input int budget);
    int sent;
    int got;
    sent = 0;
    while (sent < budget) begin
      drive_sequence(got);
      sent += got;
    end
  endtask

  initial begin
    logic [15:0] new_smooth;
    logic [14:0] new_min;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(REG_SMOOTH_TIME, {16'd0, DIR_ROWS[i].dt});
        cfg_write(REG_MIN_SPEED, {16'd0, DIR_ROWS[i].coeff});
      end else begin
        push_item(DIR_ROWS[i].op, DIR_ROWS[i].raw, DIR_ROWS[i].dt, DIR_ROWS[i].coeff,
                  DIR_ROWS[i].kind == ROW_CHECK,
                  '{value: DIR_ROWS[i].exp_value, chg: DIR_ROWS[i].exp_chg});
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin new_smooth = 16'd1;     new_min = 15'd32767; end
        1: begin new_smooth = 16'd65535; new_min = 15'd0;     end
        2: begin new_smooth = 16'd1000;  new_min = 15'd1024;  end
        4: begin new_smooth = 16'd0;     new_min = 15'($urandom); end
        5: begin
          new_smooth = 16'($urandom_range(255, 1));
          new_min    = 15'($urandom_range(4095));
        end
        6: begin new_smooth = 16'($urandom_range(65535, 1)); new_min = 15'd32767; end
        default: begin
          new_smooth = 16'($urandom_range(65535, 1));
          new_min    = 15'($urandom);
        end
      endcase
      cfg_write(REG_SMOOTH_TIME, {16'd0, new_smooth});
      cfg_write(REG_MIN_SPEED, {17'd0, new_min});
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      run_phase(PHASE_ITEMS);
      if (ph == 5) begin
        drive_pump(130, 1'($urandom_range(1)));
      end
    end

    wait_idle();
    if (mismatches == 0 && pending_axis_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
